[sv/bf3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

   localparam int MAX_SIZE     = 1024;
   localparam int CHANNEL_BITS = 16;
   localparam int ADDR_BITS    = $clog2(MAX_SIZE);
   localparam int CNT_BITS     = ADDR_BITS + 1;
   localparam int SIZE_BITS    = 11;
   localparam int SIZE_RESET   = 1024;
   localparam int SUM_BITS     = CHANNEL_BITS + 4;
   localparam int RECIP_BITS   = 20;
   localparam int PROD_BITS    = SUM_BITS + RECIP_BITS;
   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);

   // reciprocals for exact truncating division of window sums
   localparam logic [RECIP_BITS-1:0] RECIP_NINE = RECIP_BITS'(932068);
   localparam int                    SHIFT_NINE = 23;
   localparam logic [RECIP_BITS-1:0] RECIP_SIX  = RECIP_BITS'(699051);
   localparam int                    SHIFT_SIX  = 22;
   localparam int                    SHIFT_FOUR = 2;

   // pixel count of a neighborhood
   localparam logic [1:0] CNT_FOUR = 2'd0;
   localparam logic [1:0] CNT_SIX  = 2'd1;
   localparam logic [1:0] CNT_NINE = 2'd2;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } bf3_pixel_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] red;
      logic [SUM_BITS-1:0] green;
      logic [SUM_BITS-1:0] blue;
      logic [1:0]          count;
      logic                last;
   } bf3_entry_type;

   typedef struct packed {
      logic full;
      logic valid;
   } bf3_q_status_type;

endpackage

`default_nettype wire

[sv/bf3_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bf3_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] in_red;
   logic [15:0] in_green;
   logic [15:0] in_blue;

   modport source (output valid, action, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

[sv/bf3_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bf3_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_red;
   logic [15:0] out_green;
   logic [15:0] out_blue;
   logic        frame_last;

   modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

`default_nettype wire

[sv/bf3_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bf3_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bf3_req_if.sink                            req_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [bf3_pkg::SIZE_BITS-1:0] csr_wr_data,
   output logic                               push,
   output bf3_pkg::bf3_entry_type             push_data,
   input  bf3_pkg::bf3_q_status_type          q_status
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_READ       = 3'd1;
   localparam logic [2:0] S_OUT1       = 3'd2;
   localparam logic [2:0] S_OUT2       = 3'd3;
   localparam logic [2:0] S_DRAIN_RD   = 3'd4;
   localparam logic [2:0] S_DRAIN_ACC  = 3'd5;
   localparam logic [2:0] S_DRAIN_PUSH = 3'd6;

   localparam int CB = bf3_pkg::CNT_BITS;
   localparam int AB = bf3_pkg::ADDR_BITS;
   localparam int SB = bf3_pkg::SUM_BITS;

   logic [2:0]                      state_ff, state_in;
   logic [bf3_pkg::SIZE_BITS-1:0]   size_ff;
   logic [CB-1:0]                   row_ff, row_in;
   logic [CB-1:0]                   col_ff, col_in;
   logic [CB-1:0]                   drain_ff, drain_in;
   logic [CB-1:0]                   dcol_ff, dcol_in;
   logic [CB-1:0]                   dhi_ff, dhi_in;
   logic                            e2_ff, e2_in;
   logic                            cl_ff, cl_in;
   logic                            rl_ff, rl_in;
   bf3_pkg::bf3_pixel_type          px_ff;
   bf3_pkg::bf3_pixel_type          older_q_ff, newer_q_ff;
   bf3_pkg::bf3_pixel_type          win_ff [9];
   logic [SB-1:0]                   acc_r_ff, acc_g_ff, acc_b_ff;
   logic [CB-1:0]                   n_size;
   logic [AB-1:0]                   rd_addr;
   logic                            accept;
   logic                            win_shift;

   bf3_pkg::bf3_pixel_type older_mem [bf3_pkg::MAX_SIZE];
   bf3_pkg::bf3_pixel_type newer_mem [bf3_pkg::MAX_SIZE];

   // clamp the configured size to the supported range
   always_comb begin
      int s;
      s = int'(size_ff);
      if (s < 2) s = 2;
      if (s > bf3_pkg::MAX_SIZE) s = bf3_pkg::MAX_SIZE;
      n_size = CB'(s);
   end

   // masked window sum for one output word
   function automatic bf3_pkg::bf3_entry_type win_sum(input logic cl, input logic rl);
      bf3_pkg::bf3_entry_type e;
      e = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if ((c >= int'(cl)) && (r >= int'(rl))) begin
               e.red   = e.red   + SB'(win_ff[c*3+r].red);
               e.green = e.green + SB'(win_ff[c*3+r].green);
               e.blue  = e.blue  + SB'(win_ff[c*3+r].blue);
            end
         end
      end
      if (!cl && !rl)     e.count = bf3_pkg::CNT_NINE;
      else if (cl && rl)  e.count = bf3_pkg::CNT_FOUR;
      else                e.count = bf3_pkg::CNT_SIX;
      e.last = 1'b0;
      return e;
   endfunction

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rd_addr       = (state_ff == S_IDLE) ? col_ff[AB-1:0] : dcol_ff[AB-1:0];
   assign win_shift     = (state_ff == S_READ);

   // sequence one word through read, update and result push
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      drain_in = drain_ff;
      dcol_in  = dcol_ff;
      dhi_in   = dhi_ff;
      e2_in    = e2_ff;
      cl_in    = cl_ff;
      rl_in    = rl_ff;
      push      = 1'b0;
      push_data = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_bus.action) begin
                  if (row_ff < n_size) state_in = S_READ;
               end else if ((row_ff >= n_size) && (drain_ff < n_size)) begin
                  dcol_in  = (drain_ff >= CB'(1)) ? drain_ff - CB'(1) : '0;
                  dhi_in   = (drain_ff + CB'(1) < n_size) ? drain_ff + CB'(1)
                                                          : n_size - CB'(1);
                  state_in = S_DRAIN_RD;
               end
            end
         end
         S_READ: begin
            e2_in = (row_ff >= CB'(1)) && (col_ff == n_size - CB'(1));
            cl_in = (col_ff < CB'(2));
            rl_in = (row_ff < CB'(2));
            if (col_ff + CB'(1) >= n_size) begin
               col_in = '0;
               row_in = row_ff + CB'(1);
            end else begin
               col_in = col_ff + CB'(1);
            end
            if ((row_ff >= CB'(1)) && (col_ff >= CB'(1)))           state_in = S_OUT1;
            else if ((row_ff >= CB'(1)) && (col_ff == n_size - CB'(1))) state_in = S_OUT2;
            else                                                    state_in = S_IDLE;
         end
         S_OUT1: begin
            push_data = win_sum(cl_ff, rl_ff);
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = e2_ff ? S_OUT2 : S_IDLE;
            end
         end
         S_OUT2: begin
            push_data = win_sum(1'b1, rl_ff);
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DRAIN_RD: begin
            state_in = S_DRAIN_ACC;
         end
         S_DRAIN_ACC: begin
            if (dcol_ff == dhi_ff) begin
               state_in = S_DRAIN_PUSH;
            end else begin
               dcol_in  = dcol_ff + CB'(1);
               state_in = S_DRAIN_RD;
            end
         end
         S_DRAIN_PUSH: begin
            push_data.red   = acc_r_ff;
            push_data.green = acc_g_ff;
            push_data.blue  = acc_b_ff;
            // three columns away from both ends of the row, two at either end
            push_data.count = ((drain_ff != '0) && (drain_ff != n_size - CB'(1)))
                              ? bf3_pkg::CNT_SIX : bf3_pkg::CNT_FOUR;
            push_data.last  = (drain_ff == n_size - CB'(1));
            if (!q_status.full) begin
               push = 1'b1;
               if (push_data.last) begin
                  row_in   = '0;
                  col_in   = '0;
                  drain_in = '0;
               end else begin
                  drain_in = drain_ff + CB'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // restart the frame on a size write
      if (csr_wr_en) begin
         row_in   = '0;
         col_in   = '0;
         drain_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= bf3_pkg::SIZE_BITS'(bf3_pkg::SIZE_RESET);
         row_ff   <= '0;
         col_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         drain_ff <= drain_in;
         if (csr_wr_en) size_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dcol_ff <= dcol_in;
      dhi_ff  <= dhi_in;
      e2_ff   <= e2_in;
      cl_ff   <= cl_in;
      rl_ff   <= rl_in;
      if (accept) begin
         px_ff.red   <= req_bus.in_red[bf3_pkg::CHANNEL_BITS-1:0];
         px_ff.green <= req_bus.in_green[bf3_pkg::CHANNEL_BITS-1:0];
         px_ff.blue  <= req_bus.in_blue[bf3_pkg::CHANNEL_BITS-1:0];
      end
      if (state_ff == S_IDLE) begin
         acc_r_ff <= '0;
         acc_g_ff <= '0;
         acc_b_ff <= '0;
      end else if (state_ff == S_DRAIN_ACC) begin
         acc_r_ff <= acc_r_ff + SB'(older_q_ff.red)   + SB'(newer_q_ff.red);
         acc_g_ff <= acc_g_ff + SB'(older_q_ff.green) + SB'(newer_q_ff.green);
         acc_b_ff <= acc_b_ff + SB'(older_q_ff.blue)  + SB'(newer_q_ff.blue);
      end
   end

   // row stores: registered read, write back once the old column is out
   always_ff @(posedge clock) begin
      older_q_ff <= older_mem[rd_addr];
      newer_q_ff <= newer_mem[rd_addr];
      if (win_shift) begin
         older_mem[col_ff[AB-1:0]] <= newer_q_ff;
         newer_mem[col_ff[AB-1:0]] <= px_ff;
      end
   end

   // advance the window by one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (win_shift) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= win_ff[i+3];
         win_ff[6] <= older_q_ff;
         win_ff[7] <= newer_q_ff;
         win_ff[8] <= px_ff;
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full) else $error("push into a full queue");
   a_pixel_read: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_bus.action && (row_ff < n_size)) |=> (state_ff == S_READ))
      else $error("frame pixel not read");
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.last && !csr_wr_en) |=> (row_ff == '0) && (drain_ff == '0))
      else $error("counters not cleared at end of drain");

endmodule

`default_nettype wire

[sv/bf3_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bf3_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  bf3_pkg::bf3_entry_type    push_data,
   input  wire logic                 pop,
   output bf3_pkg::bf3_entry_type    pop_data,
   output bf3_pkg::bf3_q_status_type status
);

   localparam int PB = bf3_pkg::Q_PTR_BITS;

   bf3_pkg::bf3_entry_type   entry_ff [bf3_pkg::Q_DEPTH];
   logic [PB-1:0]            wr_ff, rd_ff;
   logic [PB:0]              fill_ff;

   assign status.full  = (fill_ff == (PB+1)'(bf3_pkg::Q_DEPTH));
   assign status.valid = (fill_ff != '0);
   assign pop_data     = entry_ff[rd_ff];

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PB'(1);
         if (pop)  rd_ff <= rd_ff + PB'(1);
         fill_ff <= fill_ff + (PB+1)'(push) - (PB+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_data;
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.valid) else $error("pop from an empty queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (PB+1)'(bf3_pkg::Q_DEPTH)) else $error("queue fill out of range");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (fill_ff == $past(fill_ff) + (PB+1)'(1)))
      else $error("queue fill did not step");

endmodule

`default_nettype wire

[sv/bf3_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bf3_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  bf3_pkg::bf3_q_status_type q_status,
   input  bf3_pkg::bf3_entry_type    pop_data,
   output logic                      pop,
   bf3_rsp_if.source                 rsp_bus
);

   localparam int PW = bf3_pkg::PROD_BITS;

   logic          s1_v_ff;
   logic [PW-1:0] pr_ff, pg_ff, pb_ff;
   logic [1:0]    cnt_ff;
   logic          last_ff;
   logic          out_v_ff;
   logic [15:0]   or_ff, og_ff, ob_ff;
   logic          ol_ff;
   logic          out_go;
   logic          s1_go;
   logic [15:0]   qr, qg, qb;

   assign out_go = !out_v_ff || rsp_bus.ready;
   assign s1_go  = !s1_v_ff || out_go;
   assign pop    = q_status.valid && s1_go;

   // pick the multiplier for the pixel count
   function automatic logic [PW-1:0] scale(input logic [bf3_pkg::SUM_BITS-1:0] s,
                                           input logic [1:0] cnt);
      logic [PW-1:0] p;
      case (cnt)
         bf3_pkg::CNT_NINE: p = PW'(s) * PW'(bf3_pkg::RECIP_NINE);
         bf3_pkg::CNT_SIX:  p = PW'(s) * PW'(bf3_pkg::RECIP_SIX);
         default:           p = PW'(s);
      endcase
      return p;
   endfunction

   function automatic logic [15:0] take(input logic [PW-1:0] p, input logic [1:0] cnt);
      logic [15:0] q;
      case (cnt)
         bf3_pkg::CNT_NINE: q = 16'(p >> bf3_pkg::SHIFT_NINE);
         bf3_pkg::CNT_SIX:  q = 16'(p >> bf3_pkg::SHIFT_SIX);
         default:           q = 16'(p >> bf3_pkg::SHIFT_FOUR);
      endcase
      return q;
   endfunction

   assign qr = take(pr_ff, cnt_ff);
   assign qg = take(pg_ff, cnt_ff);
   assign qb = take(pb_ff, cnt_ff);

   // multiply stage
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (s1_go) s1_v_ff <= q_status.valid;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pr_ff   <= scale(pop_data.red, pop_data.count);
         pg_ff   <= scale(pop_data.green, pop_data.count);
         pb_ff   <= scale(pop_data.blue, pop_data.count);
         cnt_ff  <= pop_data.count;
         last_ff <= pop_data.last;
      end
   end

   // output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (out_go) out_v_ff <= s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (out_go && s1_v_ff) begin
         or_ff <= qr;
         og_ff <= qg;
         ob_ff <= qb;
         ol_ff <= last_ff;
      end
   end

   assign rsp_bus.valid      = out_v_ff;
   assign rsp_bus.out_red    = or_ff;
   assign rsp_bus.out_green  = og_ff;
   assign rsp_bus.out_blue   = ob_ff;
   assign rsp_bus.frame_last = ol_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_bus.ready) |=> out_v_ff) else $error("result word dropped");
   a_pop_flow: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_v_ff) else $error("popped entry lost");
   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && out_go) |=> out_v_ff) else $error("stage word not forwarded");

endmodule

`default_nettype wire

[sv/box_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  fields
// req_bus   in   action, in_red, in_green, in_blue (valid/ready)
// rsp_bus   out  out_red, out_green, out_blue, frame_last (valid/ready)
// csr       in   csr_wr_en, csr_wr_data = image_size
//
// A frame pixel passes the read state, then one output state per word pushed
// (up to 2); a drain word passes a read and an accumulate state per stored
// column (2 or 3), then a push state. A full queue holds each push.
// The back multiplies and registers in 2 stages behind a 4-word queue.
// Reset is synchronous; a stalled result holds while the front fills the queue.

module box_filter_3x3_rgb (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bf3_req_if.sink                            req_bus,
   bf3_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [bf3_pkg::SIZE_BITS-1:0] csr_wr_data
);

   logic                      push;
   bf3_pkg::bf3_entry_type    push_data;
   logic                      pop;
   bf3_pkg::bf3_entry_type    pop_data;
   bf3_pkg::bf3_q_status_type q_status;

   bf3_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_data   (push_data),
      .q_status    (q_status)
   );

   bf3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   bf3_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import bf3_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int IDLE_PCT    = 21;
   localparam int SETTLE      = 30;
   localparam int CALM_LO     = 20000;
   localparam int CALM_HI     = 32000;
   localparam int WORD_TARGET = 1500;

   typedef enum logic [1:0] {ROW_CFG, ROW_PIXEL, ROW_DRAIN} row_kind_t;
   typedef enum logic {ACT_PIXEL = 1'b0, ACT_DRAIN = 1'b1} action_t;

   typedef struct {
      row_kind_t   kind;
      logic [15:0] value;
      bit          rnd;
      bit          typed;
      logic [15:0] mean;
   } stim_row_t;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        last;
   } mean_word_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [SIZE_BITS-1:0] csr_wr_data;
   int unsigned cycles = 0;
   int fail_count = 0;
   int words_sent = 0;

   bf3_req_if req_bus();
   bf3_rsp_if rsp_bus();

   box_filter_3x3_rgb DUT (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // filter state mirror
   logic [SIZE_BITS-1:0] size_reg;
   bf3_pixel_type older_row[MAX_SIZE];
   bf3_pixel_type newer_row[MAX_SIZE];
   bf3_pixel_type window[9];
   int row_cnt, col_cnt, drain_cnt;
   mean_word_t pending_means[$];

   stim_row_t stim_rows[32] = '{
      '{ROW_CFG,   16'd0,     0, 0, 16'h0},
      '{ROW_DRAIN, 16'h0,     0, 0, 16'h0},
      '{ROW_PIXEL, 16'hFFFF,  0, 1, 16'hFFFF},
      '{ROW_PIXEL, 16'hFFFF,  0, 1, 16'hFFFF},
      '{ROW_PIXEL, 16'hFFFF,  0, 1, 16'hFFFF},
      '{ROW_PIXEL, 16'hFFFF,  0, 1, 16'hFFFF},
      '{ROW_PIXEL, 16'h1234,  0, 0, 16'h0},
      '{ROW_DRAIN, 16'h0,     0, 1, 16'hFFFF},
      '{ROW_DRAIN, 16'h0,     0, 1, 16'hFFFF},
      '{ROW_CFG,   16'd1,     0, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     0, 1, 16'h0},
      '{ROW_PIXEL, 16'h0,     0, 1, 16'h0},
      '{ROW_PIXEL, 16'h0,     0, 1, 16'h0},
      '{ROW_PIXEL, 16'h0,     0, 1, 16'h0},
      '{ROW_DRAIN, 16'hFFFF,  0, 1, 16'h0},
      '{ROW_DRAIN, 16'hFFFF,  0, 1, 16'h0},
      '{ROW_CFG,   16'd2047,  0, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_CFG,   16'd3,     0, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_PIXEL, 16'h0,     1, 0, 16'h0},
      '{ROW_DRAIN, 16'h0,     0, 0, 16'h0},
      '{ROW_DRAIN, 16'h0,     0, 0, 16'h0},
      '{ROW_DRAIN, 16'h0,     0, 0, 16'h0}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int frame_size();
      int n;
      n = size_reg;
      if (n < 2) n = 2;
      if (n > MAX_SIZE) n = MAX_SIZE;
      return n;
   endfunction

   function automatic logic [15:0] rand_channel();
      case ($urandom % 8)
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic bf3_pixel_type rand_pixel();
      bf3_pixel_type p;
      p.red   = rand_channel();
      p.green = rand_channel();
      p.blue  = rand_channel();
      return p;
   endfunction

   // queue the mean of window columns col_lo..2, rows row_lo..2
   function automatic void push_window_mean(int col_lo, int row_lo);
      int sr, sg, sb, cnt;
      mean_word_t m;
      sr = 0; sg = 0; sb = 0; cnt = 0;
      for (int c = col_lo; c < 3; c++)
         for (int r = row_lo; r < 3; r++) begin
            sr += window[c*3+r].red;
            sg += window[c*3+r].green;
            sb += window[c*3+r].blue;
            cnt++;
         end
      m.red = 16'(sr / cnt); m.green = 16'(sg / cnt); m.blue = 16'(sb / cnt);
      m.last = 1'b0;
      pending_means.push_back(m);
   endfunction

   // advance the mirror by one accepted word; -1 when the block drops it
   function automatic int predict_word(action_t act, bf3_pixel_type p);
      int n, lo, hi, sr, sg, sb, cnt, prior_count;
      mean_word_t m;
      n = frame_size();
      prior_count = pending_means.size();
      if (act == ACT_PIXEL) begin
         if (row_cnt >= n || col_cnt >= n) return -1;
         for (int i = 0; i < 6; i++) window[i] = window[i+3];
         window[6] = older_row[col_cnt];
         window[7] = newer_row[col_cnt];
         window[8] = p;
         older_row[col_cnt] = newer_row[col_cnt];
         newer_row[col_cnt] = p;
         if (row_cnt >= 1) begin
            if (col_cnt >= 1) push_window_mean(col_cnt >= 2 ? 0 : 1, row_cnt >= 2 ? 0 : 1);
            if (col_cnt == n - 1) push_window_mean(1, row_cnt >= 2 ? 0 : 1);
         end
         col_cnt++;
         if (col_cnt >= n) begin
            col_cnt = 0;
            row_cnt++;
         end
      end else begin
         if (row_cnt < n || drain_cnt >= n) return -1;
         lo = drain_cnt >= 1 ? drain_cnt - 1 : 0;
         hi = drain_cnt + 1 < n ? drain_cnt + 1 : n - 1;
         sr = 0; sg = 0; sb = 0; cnt = 0;
         for (int c = lo; c <= hi; c++) begin
            sr += older_row[c].red + newer_row[c].red;
            sg += older_row[c].green + newer_row[c].green;
            sb += older_row[c].blue + newer_row[c].blue;
            cnt += 2;
         end
         m.red = 16'(sr / cnt); m.green = 16'(sg / cnt); m.blue = 16'(sb / cnt);
         m.last = (drain_cnt == n - 1);
         pending_means.push_back(m);
         if (m.last) begin
            row_cnt = 0; col_cnt = 0; drain_cnt = 0;
         end else begin
            drain_cnt++;
         end
      end
      return pending_means.size() - prior_count;
   endfunction

   function automatic bit calm_window();
      return cycles >= CALM_LO && cycles < CALM_HI;
   endfunction

   // drive one word, hold until taken, then predict; typed rows pin the channels
   task automatic send_word(action_t act, bf3_pixel_type p, bit typed, logic [15:0] mean);
      int made;
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.in_red   <= p.red;
      req_bus.in_green <= p.green;
      req_bus.in_blue  <= p.blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      made = predict_word(act, p);
      if (made >= 0) words_sent++;
      if (typed)
         for (int k = 0; k < made; k++) begin
            pending_means[pending_means.size()-1-k].red   = mean;
            pending_means[pending_means.size()-1-k].green = mean;
            pending_means[pending_means.size()-1-k].blue  = mean;
         end
      if (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // write image_size once the block has gone quiet
   task automatic write_size(logic [SIZE_BITS-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_reg = value;
      row_cnt = 0; col_cnt = 0; drain_cnt = 0;
   endtask

   task automatic send_frame(int n);
      for (int i = 0; i < n * n; i++) begin
         if ($urandom_range(0, 99) < 4) send_word(ACT_DRAIN, rand_pixel(), 0, 16'h0);
         send_word(ACT_PIXEL, rand_pixel(), 0, 16'h0);
      end
      if ($urandom_range(0, 9) == 0) send_word(ACT_PIXEL, rand_pixel(), 0, 16'h0);
      for (int d = 0; d < n; d++) send_word(ACT_DRAIN, rand_pixel(), 0, 16'h0);
   endtask

   // stall the result side at random, except in the calm stretch
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // compare each taken result with the oldest expected mean
   always @(posedge clock) begin
      mean_word_t m;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_means.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            m = pending_means.pop_front();
            if (rsp_bus.out_red !== m.red) begin
               $error("out_red expected %h actual %h", m.red, rsp_bus.out_red);
               fail_count++;
            end
            if (rsp_bus.out_green !== m.green) begin
               $error("out_green expected %h actual %h", m.green, rsp_bus.out_green);
               fail_count++;
            end
            if (rsp_bus.out_blue !== m.blue) begin
               $error("out_blue expected %h actual %h", m.blue, rsp_bus.out_blue);
               fail_count++;
            end
            if (rsp_bus.frame_last !== m.last) begin
               $error("frame_last expected %b actual %b", m.last, rsp_bus.frame_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL box_filter_3x3_rgb");
         $finish;
      end
   end

   initial begin
      bf3_pixel_type p;
      int n, pick, cut;
      bit need_cfg;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.action   <= ACT_PIXEL;
      req_bus.in_red   <= '0;
      req_bus.in_green <= '0;
      req_bus.in_blue  <= '0;
      size_reg = SIZE_BITS'(SIZE_RESET);
      row_cnt = 0; col_cnt = 0; drain_cnt = 0;
      for (int i = 0; i < MAX_SIZE; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CFG) begin
            write_size(SIZE_BITS'(stim_rows[i].value));
         end else begin
            if (stim_rows[i].rnd) p = rand_pixel();
            else p = '{stim_rows[i].value, stim_rows[i].value, stim_rows[i].value};
            send_word(stim_rows[i].kind == ROW_DRAIN ? ACT_DRAIN : ACT_PIXEL, p,
                      stim_rows[i].typed, stim_rows[i].mean);
         end
      end

      // random frames, mostly small and well formed
      need_cfg = 1'b1;
      while (words_sent < WORD_TARGET) begin
         if (need_cfg || $urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) n = $urandom_range(2, 5);
            else if (pick < 97) n = $urandom_range(6, 16);
            else n = 24;
            if (n == 2 && $urandom_range(0, 2) == 0) write_size(SIZE_BITS'($urandom_range(0, 1)));
            else write_size(SIZE_BITS'(n));
            need_cfg = 1'b0;
         end
         n = frame_size();
         if ($urandom_range(0, 9) == 0) begin
            // broken frame: stop short, poke a drain, then restart by a write
            cut = $urandom_range(0, n * n - 1);
            for (int i = 0; i < cut; i++) send_word(ACT_PIXEL, rand_pixel(), 0, 16'h0);
            send_word(ACT_DRAIN, rand_pixel(), 0, 16'h0);
            if ($urandom_range(0, 3) == 0) begin
               write_size(SIZE_BITS'(2047));
               for (int i = 0; i < 3; i++) send_word(ACT_PIXEL, rand_pixel(), 0, 16'h0);
            end
            need_cfg = 1'b1;
         end else begin
            send_frame(n);
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("PASS box_filter_3x3_rgb");
      else $display("FAIL box_filter_3x3_rgb");
      $finish;
   end

endmodule

[files.f]
sv/bf3_pkg.sv
sv/bf3_req_if.sv
sv/bf3_rsp_if.sv
sv/bf3_front.sv
sv/bf3_queue.sv
sv/bf3_back.sv
sv/box_filter_3x3_rgb.sv
tb/tb.sv
